// File: rtl/clock_hand_endpoint_assert.svh
// Assertion macros for the clock hand endpoint checker.
// Needs nothing else; included by the checker file only.
`ifndef CLOCK_HAND_ENDPOINT_ASSERT_SVH
`define CLOCK_HAND_ENDPOINT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held low.
`define CHEP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("clock hand endpoint: same-cycle check failed");

// Next-cycle implication, disabled while reset is held low.
`define CHEP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("clock hand endpoint: next-cycle check failed");

`endif

// File: rtl/chep_pkg.sv
// Shared constants for the clock hand endpoint: field widths, hand codes,
// divider constants and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chep_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_PHASE_BITS = 16;

  // Time fields
  localparam int OP_BITS      = 2;
  localparam int SEC_BITS     = 6;
  localparam int MIN_BITS     = 6;
  localparam int HOUR_BITS    = 5;
  localparam int ELAPSED_BITS = 17;
  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;

  // Hand kinds
  localparam logic [OP_BITS-1:0] OP_SECOND = 2'd0;
  localparam logic [OP_BITS-1:0] OP_MINUTE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_HOUR   = 2'd2;
  localparam logic [OP_BITS-1:0] OP_DAY    = 2'd3;

  // Periods split as 2^POW * ODD: 60, 3600, 43200, 86400
  localparam int POW_SEC  = 2;
  localparam int POW_MIN  = 4;
  localparam int POW_HOUR = 6;
  localparam int POW_DAY  = 7;
  localparam longint unsigned ODD_SEC = 64'd15;
  localparam longint unsigned ODD_MIN = 64'd225;
  localparam longint unsigned ODD_DAY = 64'd675;

  // Reciprocal precision above the phase, and remainder width for correction
  localparam int RECIP_EXTRA = 11;
  localparam int REM_BITS    = 12;

  // Configuration
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 2'd1;

  // CORDIC, Q2.30 values, angles in 2^-32 turn
  localparam int ANGLE_BITS   = 32;
  localparam int TRIG_BITS    = 32;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN_INV = 32'sd652032874;
  localparam logic signed [TRIG_BITS-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  // Output scaling
  localparam int FRAC_BITS   = 4;
  localparam int OUT_EXTRA   = 6;
  localparam int ROUND_SHIFT = 26;

endpackage

`default_nettype wire

// File: rtl/chep_phase.sv
// Phase front end: elapsed units, reciprocal multiply and remainder correction.
// Four register stages; uses chep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chep_phase #(
  parameter int COORD_BITS = chep_pkg::DEF_COORD_BITS,
  parameter int PHASE_BITS = chep_pkg::DEF_PHASE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic [chep_pkg::OP_BITS-1:0]      op,
  input  logic [chep_pkg::SEC_BITS-1:0]     seconds,
  input  logic [chep_pkg::MIN_BITS-1:0]     minutes,
  input  logic [chep_pkg::HOUR_BITS-1:0]    hours,
  input  logic [COORD_BITS-1:0]             len_in,
  output logic                              out_v,
  output logic [PHASE_BITS-1:0]             phase,
  output logic [COORD_BITS-1:0]             len_out
);
  import chep_pkg::*;

  localparam int EW  = ELAPSED_BITS;
  localparam int MW  = PHASE_BITS + 8;
  localparam int PRW = EW + MW;
  localparam int NW  = EW + PHASE_BITS;
  localparam int RW  = REM_BITS;
  localparam int QW  = (PHASE_BITS > RW) ? PHASE_BITS : RW;
  localparam longint unsigned RECIP_K = 64'd1 << (PHASE_BITS + RECIP_EXTRA);
  localparam logic [MW-1:0] MUL_SEC = MW'(RECIP_K / ODD_SEC);
  localparam logic [MW-1:0] MUL_MIN = MW'(RECIP_K / ODD_MIN);
  localparam logic [MW-1:0] MUL_DAY = MW'(RECIP_K / ODD_DAY);

  // Stage A: elapsed units
  logic                  v_a_r;
  logic [OP_BITS-1:0]    op_a_r;
  logic [COORD_BITS-1:0] len_a_r;
  logic [EW-1:0]         e_a_r;
  logic [EW-1:0]         e_nxt;
  logic [EW-1:0]         e_sec, e_min, e_hr;

  assign e_sec = EW'(seconds);
  assign e_min = EW'(minutes) * EW'(SEC_PER_MIN);
  assign e_hr  = EW'(hours) * EW'(SEC_PER_HOUR);

  always_comb begin
    case (op)
      OP_SECOND: e_nxt = e_sec;
      OP_MINUTE: e_nxt = e_min + e_sec;
      default:   e_nxt = e_hr + e_min + e_sec;
    endcase
  end

  // Stage B: elapsed times reciprocal; low bits of elapsed << shift
  logic                  v_b_r;
  logic [OP_BITS-1:0]    op_b_r;
  logic [COORD_BITS-1:0] len_b_r;
  logic [PRW-1:0]        prod_b_r;
  logic [RW-1:0]         nlo_b_r;
  logic [MW-1:0]         mul_sel;
  logic [NW-1:0]         n_wide;

  always_comb begin
    case (op_a_r)
      OP_SECOND: begin
        mul_sel = MUL_SEC;
        n_wide  = NW'(e_a_r) << (PHASE_BITS - POW_SEC);
      end
      OP_MINUTE: begin
        mul_sel = MUL_MIN;
        n_wide  = NW'(e_a_r) << (PHASE_BITS - POW_MIN);
      end
      OP_HOUR: begin
        mul_sel = MUL_DAY;
        n_wide  = NW'(e_a_r) << (PHASE_BITS - POW_HOUR);
      end
      default: begin
        mul_sel = MUL_DAY;
        n_wide  = NW'(e_a_r) << (PHASE_BITS - POW_DAY);
      end
    endcase
  end

  // Stage C: quotient estimate and its product with the odd divisor
  logic                  v_c_r;
  logic [OP_BITS-1:0]    op_c_r;
  logic [COORD_BITS-1:0] len_c_r;
  logic [PHASE_BITS-1:0] q0_c_r;
  logic [RW-1:0]         qb_c_r;
  logic [RW-1:0]         nlo_c_r;
  logic [QW-1:0]         q0;
  logic [RW-1:0]         odd_b;

  always_comb begin
    case (op_b_r)
      OP_SECOND: begin
        q0    = prod_b_r[(RECIP_EXTRA + POW_SEC) +: QW];
        odd_b = RW'(ODD_SEC);
      end
      OP_MINUTE: begin
        q0    = prod_b_r[(RECIP_EXTRA + POW_MIN) +: QW];
        odd_b = RW'(ODD_MIN);
      end
      OP_HOUR: begin
        q0    = prod_b_r[(RECIP_EXTRA + POW_HOUR) +: QW];
        odd_b = RW'(ODD_DAY);
      end
      default: begin
        q0    = prod_b_r[(RECIP_EXTRA + POW_DAY) +: QW];
        odd_b = RW'(ODD_DAY);
      end
    endcase
  end

  // Stage D: estimate is low by at most one; bump it when the remainder overflows
  logic                  v_d_r;
  logic [COORD_BITS-1:0] len_d_r;
  logic [PHASE_BITS-1:0] phase_d_r;
  logic [RW-1:0]         odd_c;
  logic [RW-1:0]         rem;
  logic                  bump;

  always_comb begin
    case (op_c_r)
      OP_SECOND: odd_c = RW'(ODD_SEC);
      OP_MINUTE: odd_c = RW'(ODD_MIN);
      default:   odd_c = RW'(ODD_DAY);
    endcase
  end

  assign rem  = nlo_c_r - qb_c_r;
  assign bump = (rem >= odd_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_v;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r    <= op;
      len_a_r   <= len_in;
      e_a_r     <= e_nxt;
      op_b_r    <= op_a_r;
      len_b_r   <= len_a_r;
      prod_b_r  <= PRW'(e_a_r) * PRW'(mul_sel);
      nlo_b_r   <= n_wide[RW-1:0];
      op_c_r    <= op_b_r;
      len_c_r   <= len_b_r;
      q0_c_r    <= q0[PHASE_BITS-1:0];
      qb_c_r    <= q0[RW-1:0] * odd_b;
      nlo_c_r   <= nlo_b_r;
      len_d_r   <= len_c_r;
      phase_d_r <= q0_c_r + PHASE_BITS'(bump);
    end
  end

  assign out_v   = v_d_r;
  assign phase   = phase_d_r;
  assign len_out = len_d_r;

endmodule

`default_nettype wire

// File: rtl/chep_cordic.sv
// Pipelined rotation-mode CORDIC: one iteration per stage plus a quadrant stage.
// Uses chep_pkg for the gain, arctangent table and widths.
`timescale 1ns / 1ps
`default_nettype none

module chep_cordic #(
  parameter int COORD_BITS = chep_pkg::DEF_COORD_BITS,
  parameter int PHASE_BITS = chep_pkg::DEF_PHASE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_v,
  input  logic [PHASE_BITS-1:0]                  phase,
  input  logic [COORD_BITS-1:0]                  len_in,
  output logic                                   out_v,
  output logic signed [chep_pkg::TRIG_BITS-1:0]  sin_out,
  output logic signed [chep_pkg::TRIG_BITS-1:0]  cos_out,
  output logic [COORD_BITS-1:0]                  len_out
);
  import chep_pkg::*;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  logic [ANGLE_BITS-1:0]         angle;
  logic signed [TRIG_BITS-1:0]   z_init;

  assign angle  = {phase, {(ANGLE_BITS - PHASE_BITS){1'b0}}};
  assign z_init = {2'b00, angle[ANGLE_BITS-3:0]};

  logic                        v_r    [CORDIC_STEPS];
  logic [1:0]                  quad_r [CORDIC_STEPS];
  logic [COORD_BITS-1:0]       len_r  [CORDIC_STEPS];
  logic signed [TRIG_BITS-1:0] x_r    [CORDIC_STEPS];
  logic signed [TRIG_BITS-1:0] y_r    [CORDIC_STEPS];
  logic signed [TRIG_BITS-1:0] z_r    [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic                        v_in;
    logic [1:0]                  quad_in;
    logic [COORD_BITS-1:0]       len_i;
    logic signed [TRIG_BITS-1:0] x_in, y_in, z_in, dx, dy;

    if (i == 0) begin : g_head
      assign v_in    = in_v;
      assign quad_in = phase[PHASE_BITS-1 -: 2];
      assign len_i   = len_in;
      assign x_in    = CORDIC_GAIN_INV;
      assign y_in    = '0;
      assign z_in    = z_init;
    end else begin : g_body
      assign v_in    = v_r[i-1];
      assign quad_in = quad_r[i-1];
      assign len_i   = len_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    // rotate towards zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[i] <= quad_in;
        len_r[i]  <= len_i;
        if (!z_in[TRIG_BITS-1]) begin
          x_r[i] <= x_in - dx;
          y_r[i] <= y_in + dy;
          z_r[i] <= z_in - ATAN_TURN[i];
        end else begin
          x_r[i] <= x_in + dx;
          y_r[i] <= y_in - dy;
          z_r[i] <= z_in + ATAN_TURN[i];
        end
      end
    end
  end

  // Quadrant stage
  logic                        v_q_r;
  logic [COORD_BITS-1:0]       len_q_r;
  logic signed [TRIG_BITS-1:0] sin_q_r, cos_q_r;
  logic signed [TRIG_BITS-1:0] sin_nxt, cos_nxt;
  logic signed [TRIG_BITS-1:0] x_last, y_last;

  assign x_last = x_r[CORDIC_STEPS-1];
  assign y_last = y_r[CORDIC_STEPS-1];

  always_comb begin
    case (quad_r[CORDIC_STEPS-1])
      QUAD_FIRST: begin
        sin_nxt = y_last;
        cos_nxt = x_last;
      end
      QUAD_SECOND: begin
        sin_nxt = x_last;
        cos_nxt = -y_last;
      end
      QUAD_THIRD: begin
        sin_nxt = -y_last;
        cos_nxt = -x_last;
      end
      default: begin
        sin_nxt = -x_last;
        cos_nxt = y_last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_q_r <= 1'b0;
    end else if (en) begin
      v_q_r <= v_r[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_q_r <= len_r[CORDIC_STEPS-1];
      sin_q_r <= sin_nxt;
      cos_q_r <= cos_nxt;
    end
  end

  assign out_v   = v_q_r;
  assign sin_out = sin_q_r;
  assign cos_out = cos_q_r;
  assign len_out = len_q_r;

endmodule

`default_nettype wire

// File: rtl/chep_scale.sv
// Length scaling: registered length times sine and cosine, then rounding
// and the centre offset. Uses chep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chep_scale #(
  parameter int COORD_BITS = chep_pkg::DEF_COORD_BITS
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                en,
  input  logic                                                in_v,
  input  logic signed [chep_pkg::TRIG_BITS-1:0]               sin_in,
  input  logic signed [chep_pkg::TRIG_BITS-1:0]               cos_in,
  input  logic [COORD_BITS-1:0]                               len_in,
  input  logic [COORD_BITS-1:0]                               center_x,
  input  logic [COORD_BITS-1:0]                               center_y,
  output logic                                                out_v,
  output logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0]    tip_x,
  output logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0]    tip_y
);
  import chep_pkg::*;

  localparam int OW = COORD_BITS + OUT_EXTRA;
  localparam int PW = COORD_BITS + TRIG_BITS + 1;
  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (ROUND_SHIFT - 1);

  logic                 v_p_r;
  logic signed [PW-1:0] prod_s_r, prod_c_r;
  logic signed [COORD_BITS:0] len_s;

  assign len_s = {1'b0, len_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r <= 1'b0;
    end else if (en) begin
      v_p_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_s_r <= len_s * sin_in;
      prod_c_r <= len_s * cos_in;
    end
  end

  // round half up, then drop the fraction below four bits; wrap to the field
  logic [PW-1:0] sum_s, sum_c;
  logic [OW-1:0] term_s, term_c;
  logic [OW-1:0] base_x, base_y;

  assign sum_s  = prod_s_r + ROUND_HALF;
  assign sum_c  = prod_c_r + ROUND_HALF;
  assign term_s = sum_s[ROUND_SHIFT +: OW];
  assign term_c = sum_c[ROUND_SHIFT +: OW];
  assign base_x = OW'({center_x, {FRAC_BITS{1'b0}}});
  assign base_y = OW'({center_y, {FRAC_BITS{1'b0}}});

  assign out_v = v_p_r;
  assign tip_x = base_x + term_s;
  assign tip_y = base_y - term_c;

endmodule

`default_nettype wire

// File: rtl/chep_outbuf.sv
// Output register with one skid word; its ready holds the whole pipeline.
// Uses chep_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module chep_outbuf #(
  parameter int COORD_BITS = chep_pkg::DEF_COORD_BITS
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             up_valid,
  input  logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0] up_tip_x,
  input  logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0] up_tip_y,
  output logic                                             up_ready,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0] out_tip_x,
  output logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0] out_tip_y
);
  import chep_pkg::*;

  localparam int OW = COORD_BITS + OUT_EXTRA;

  logic                 out_v_r, out_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  logic signed [OW-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic signed [OW-1:0] skid_x_r, skid_x_nxt, skid_y_r, skid_y_nxt;
  logic                 take, up_fire;

  assign take    = out_v_r & ~out_stall;
  assign up_fire = up_valid & ~skid_v_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_x_nxt  = out_x_r;
    out_y_nxt  = out_y_r;
    skid_x_nxt = skid_x_r;
    skid_y_nxt = skid_y_r;
    if (up_fire) begin
      if (!out_v_r || take) begin
        out_v_nxt = 1'b1;
        out_x_nxt = up_tip_x;
        out_y_nxt = up_tip_y;
      end else begin
        // output held: park the word
        skid_v_nxt = 1'b1;
        skid_x_nxt = up_tip_x;
        skid_y_nxt = up_tip_y;
      end
    end else if (take) begin
      out_v_nxt  = skid_v_r;
      out_x_nxt  = skid_x_r;
      out_y_nxt  = skid_y_r;
      skid_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    skid_x_r <= skid_x_nxt;
    skid_y_r <= skid_y_nxt;
  end

  assign up_ready  = ~skid_v_r;
  assign out_valid = out_v_r;
  assign out_tip_x = out_x_r;
  assign out_tip_y = out_y_r;

endmodule

`default_nettype wire

// File: rtl/clock_hand_endpoint.sv
// Top level of the clock hand endpoint: centre registers and the pipeline.
// Depends on chep_pkg, chep_phase, chep_cordic, chep_scale and chep_outbuf.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+---------------------------------------
//   in_     | in        | in_valid / in_stall | op, seconds, minutes, hours, hand_length
//   out_    | out       | out_valid/out_stall | tip_x, tip_y
//   cfg_    | in        | cfg_valid/cfg_ready | index, data (centre x or y)
//
// One word accepted per cycle while in_stall is low; a result passes the four
// phase stages, the 30-stage CORDIC, the quadrant stage, the multiply stage
// and the output register.
// Synchronous active-low reset clears all valid bits and both centre registers.
// A held output parks one word in the skid register; in_stall (registered)
// then freezes every stage until that word drains.
`timescale 1ns / 1ps
`default_nettype none

module clock_hand_endpoint #(
  parameter int COORD_BITS = chep_pkg::DEF_COORD_BITS,
  parameter int PHASE_BITS = chep_pkg::DEF_PHASE_BITS
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  output logic                                             in_stall,
  input  logic [chep_pkg::OP_BITS-1:0]                     in_op,
  input  logic [chep_pkg::SEC_BITS-1:0]                    in_seconds,
  input  logic [chep_pkg::MIN_BITS-1:0]                    in_minutes,
  input  logic [chep_pkg::HOUR_BITS-1:0]                   in_hours,
  input  logic [COORD_BITS-1:0]                            in_hand_length,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0] out_tip_x,
  output logic signed [COORD_BITS+chep_pkg::OUT_EXTRA-1:0] out_tip_y,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [chep_pkg::CFG_INDEX_BITS-1:0]              cfg_index,
  input  logic [COORD_BITS-1:0]                            cfg_data
);
  import chep_pkg::*;

  localparam int OW = COORD_BITS + OUT_EXTRA;

  // Centre registers
  logic [COORD_BITS-1:0] center_x_r, center_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                        en, up_ready;
  logic                        v_ph, v_cd, v_sc;
  logic [PHASE_BITS-1:0]       phase;
  logic [COORD_BITS-1:0]       len_ph, len_cd;
  logic signed [TRIG_BITS-1:0] sin_cd, cos_cd;
  logic signed [OW-1:0]        tip_x_sc, tip_y_sc;

  assign en       = up_ready;
  assign in_stall = ~up_ready;

  chep_phase #(
    .COORD_BITS(COORD_BITS),
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_valid),
    .op      (in_op),
    .seconds (in_seconds),
    .minutes (in_minutes),
    .hours   (in_hours),
    .len_in  (in_hand_length),
    .out_v   (v_ph),
    .phase   (phase),
    .len_out (len_ph)
  );

  chep_cordic #(
    .COORD_BITS(COORD_BITS),
    .PHASE_BITS(PHASE_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v_ph),
    .phase   (phase),
    .len_in  (len_ph),
    .out_v   (v_cd),
    .sin_out (sin_cd),
    .cos_out (cos_cd),
    .len_out (len_cd)
  );

  chep_scale #(
    .COORD_BITS(COORD_BITS)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_cd),
    .sin_in   (sin_cd),
    .cos_in   (cos_cd),
    .len_in   (len_cd),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .out_v    (v_sc),
    .tip_x    (tip_x_sc),
    .tip_y    (tip_y_sc)
  );

  chep_outbuf #(
    .COORD_BITS(COORD_BITS)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (v_sc),
    .up_tip_x  (tip_x_sc),
    .up_tip_y  (tip_y_sc),
    .up_ready  (up_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tip_x (out_tip_x),
    .out_tip_y (out_tip_y)
  );

endmodule

`default_nettype wire

// File: rtl/chep_checker.sv
// Port-level checks on the clock hand endpoint, bound to the top level.
// Depends on clock_hand_endpoint_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "clock_hand_endpoint_assert.svh"

module chep_checker #(
  parameter int OUT_BITS = chep_pkg::DEF_COORD_BITS + chep_pkg::OUT_EXTRA
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [OUT_BITS-1:0] out_tip_x,
  input logic [OUT_BITS-1:0] out_tip_y
);

  // input holds only while a finished word already waits at the output
  `CHEP_ASSERT_IMP(a_stall_needs_word, clk, rst_n, in_stall, out_valid)
  // input stall starts only after the output was held
  `CHEP_ASSERT_IMP(a_stall_cause, clk, rst_n, $rose(in_stall), $past(out_valid && out_stall))
  // a taken output drains the skid word and so frees the input
  `CHEP_ASSERT_NXT(a_stall_drain, clk, rst_n, in_stall && !out_stall, !in_stall)
  // held result keeps its word
  `CHEP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_tip_x) && $stable(out_tip_y))

endmodule

bind clock_hand_endpoint chep_checker #(
  .OUT_BITS(COORD_BITS + chep_pkg::OUT_EXTRA)
) u_chep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_tip_x (out_tip_x),
  .out_tip_y (out_tip_y)
);

`default_nettype wire
